// ===== design/cks_pkg.sv =====
// shared types and constants of the cross kernel sharpen block
package cks_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int PIX_W  = 48;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [2:0] REG_FRAME_WIDTH     = 3'd0;
    localparam logic [2:0] REG_SHARPEN_ENABLE  = 3'd1;
    localparam logic [2:0] REG_LUMA_ONLY       = 3'd2;
    localparam logic [2:0] REG_CENTER_GAIN     = 3'd3;
    localparam logic [2:0] REG_HORIZONTAL_GAIN = 3'd4;
    localparam logic [2:0] REG_VERTICAL_GAIN   = 3'd5;

    localparam logic [12:0] RST_FRAME_WIDTH  = 13'd1920;
    localparam logic [17:0] RST_CENTER_GAIN  = 18'd16384;

    typedef struct packed {
        logic        opcode;
        logic        frame_start;
        logic [15:0] chan_a;
        logic [15:0] chan_b;
        logic [15:0] chan_c;
    } t_pix_in;

    typedef struct packed {
        logic [15:0] out_a;
        logic [15:0] out_b;
        logic [15:0] out_c;
        logic        row_end;
    } t_pix_out;

    typedef struct packed {
        logic [12:0] frame_width;
        logic        sharpen_enable;
        logic        luma_only;
        logic [17:0] center_gain;
        logic [15:0] horizontal_gain;
        logic [15:0] vertical_gain;
    } t_cfg;

    typedef struct packed {
        logic ld2;
        logic ld3;
    } t_pipe_ctl;

endpackage

// ===== design/cks_stream_if.sv =====
// valid/ready stream interface with a typed payload
interface cks_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/cks_regs.sv =====
// apb configuration registers
module cks_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cks_pkg::ADDR_W-1:0] paddr,
    input  logic [cks_pkg::DATA_W-1:0] pwdata,
    output logic [cks_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output cks_pkg::t_cfg              o_cfg
);
    import cks_pkg::*;

    t_cfg       r_cfg;
    logic       wr;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width     <= RST_FRAME_WIDTH;
            r_cfg.sharpen_enable  <= 1'b0;
            r_cfg.luma_only       <= 1'b0;
            r_cfg.center_gain     <= RST_CENTER_GAIN;
            r_cfg.horizontal_gain <= 16'd0;
            r_cfg.vertical_gain   <= 16'd0;
        end else if (wr) begin
            unique case (idx)
                REG_FRAME_WIDTH:     r_cfg.frame_width     <= pwdata[12:0];
                REG_SHARPEN_ENABLE:  r_cfg.sharpen_enable  <= pwdata[0];
                REG_LUMA_ONLY:       r_cfg.luma_only       <= pwdata[0];
                REG_CENTER_GAIN:     r_cfg.center_gain     <= pwdata[17:0];
                REG_HORIZONTAL_GAIN: r_cfg.horizontal_gain <= pwdata[15:0];
                REG_VERTICAL_GAIN:   r_cfg.vertical_gain   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FRAME_WIDTH:     prdata = {19'd0, r_cfg.frame_width};
            REG_SHARPEN_ENABLE:  prdata = {31'd0, r_cfg.sharpen_enable};
            REG_LUMA_ONLY:       prdata = {31'd0, r_cfg.luma_only};
            REG_CENTER_GAIN:     prdata = {14'd0, r_cfg.center_gain};
            REG_HORIZONTAL_GAIN: prdata = {16'd0, r_cfg.horizontal_gain};
            REG_VERTICAL_GAIN:   prdata = {16'd0, r_cfg.vertical_gain};
            default:             prdata = '0;
        endcase
    end

endmodule

// ===== design/cks_line_bank.sv =====
// line memory bank, one write and two registered reads per cycle
module cks_line_bank #(
    parameter  int DEPTH = 4096,
    parameter  int DW    = 48,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr0,
    input  logic [AW-1:0] i_rd_addr1,
    output logic [DW-1:0] o_rd_data0,
    output logic [DW-1:0] o_rd_data1,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd0;
    logic [DW-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd0 <= r_mem[i_rd_addr0];
            r_rd1 <= r_mem[i_rd_addr1];
        end
    end

    assign o_rd_data0 = r_rd0;
    assign o_rd_data1 = r_rd1;

endmodule

// ===== design/cks_chan_kernel.sv =====
// per channel cross kernel: product stage, then sum and clamp stage (center passes through when sharpening is off)
module cks_chan_kernel #(
    parameter int GAIN_FRAC_BITS = 14
) (
    input  logic                 i_clk,
    input  cks_pkg::t_pipe_ctl   i_ctl,
    input  logic                 i_sharpen,
    input  logic [15:0]          i_p,
    input  logic [15:0]          i_u,
    input  logic [15:0]          i_d,
    input  logic [15:0]          i_l,
    input  logic [15:0]          i_r,
    input  logic [17:0]          i_center_gain,
    input  logic [15:0]          i_h_gain,
    input  logic [15:0]          i_v_gain,
    output logic [15:0]          o_res
);
    import cks_pkg::*;

    localparam int CPW = 34 - GAIN_FRAC_BITS;
    localparam int SW  = (CPW > 18) ? CPW : 18;

    function automatic logic [15:0] side_sat(input logic [31:0] prod);
        logic [31:0] t;
        t = prod >> GAIN_FRAC_BITS;
        return (t > 32'd65535) ? 16'hFFFF : t[15:0];
    endfunction

    logic [33:0]    prod_c;
    logic [33:0]    cp_full;
    logic [CPW-1:0] r_cp;
    logic [15:0]    r_su, r_sd, r_sl, r_sr, r_p;
    logic           r_sharpen;
    logic [SW-1:0]  sides, cp_ext, diff;
    logic [15:0]    n_res, r_res;

    assign prod_c  = {16'd0, i_center_gain} * {18'd0, i_p};
    assign cp_full = prod_c >> GAIN_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_cp      <= cp_full[CPW-1:0];
            r_su      <= side_sat({16'd0, i_v_gain} * {16'd0, i_u});
            r_sd      <= side_sat({16'd0, i_v_gain} * {16'd0, i_d});
            r_sl      <= side_sat({16'd0, i_h_gain} * {16'd0, i_l});
            r_sr      <= side_sat({16'd0, i_h_gain} * {16'd0, i_r});
            r_p       <= i_p;
            r_sharpen <= i_sharpen;
        end
        if (i_ctl.ld3) begin
            r_res <= n_res;
        end
    end

    always_comb begin
        sides  = SW'(r_su) + SW'(r_sd) + SW'(r_sl) + SW'(r_sr);
        cp_ext = SW'(r_cp);
        diff   = cp_ext - sides;
        if (!r_sharpen) begin
            n_res = r_p;
        end else if (cp_ext < sides) begin
            n_res = 16'd0;
        end else if (diff > SW'(65535)) begin
            n_res = 16'hFFFF;
        end else begin
            n_res = diff[15:0];
        end
    end

    assign o_res = r_res;

endmodule

// ===== design/cross_kernel_sharpen_top.sv =====
// top level of the cross kernel sharpen block
//
//  channel   dir   transfer payload                                   modport
//  i_pix     in    opcode, frame_start, chan_a, chan_b, chan_c        sink
//  o_pix     out   out_a, out_b, out_c, row_end                       source
//  apb       in    psel/penable/pwrite/paddr/pwdata, prdata, pready   slave
//
// one pixel or drain transfer per cycle unless o_pix stalls; the output is registered.
// the two line banks set the rate: each takes up to one write and two reads per cycle.
// reset clears counters, row phase, bank select and pipeline valids; line banks
// hold no reset state and need no clearing pass.
// a stalled output holds the pipeline; input is taken whenever the first stage can move.
module cross_kernel_sharpen_top #(
    parameter int MAX_WIDTH      = 4096,
    parameter int GAIN_FRAC_BITS = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    cks_stream_if.sink                 i_pix,
    cks_stream_if.source               o_pix,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cks_pkg::ADDR_W-1:0] paddr,
    input  logic [cks_pkg::DATA_W-1:0] pwdata,
    output logic [cks_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import cks_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_INNER  = 2'd2;

    typedef struct packed {
        logic [2:0]       mask;
        logic             row_end;
        logic             sel;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] left;
    } t_s1;

    t_cfg cfg;

    cks_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [AW-1:0] r_col, r_drain;
    logic [1:0]    r_phase;
    logic          r_sel;
    logic          r_v1, r_v2, r_v3;
    logic          r_end2, r_end3;
    t_s1           r_s1;

    logic          rdy1, rdy2, rdy3, acc;
    logic [AW-1:0] last, col_e, dr_e, x, d, x_inc, addr_above;
    logic [1:0]    ph_e;
    logic          fs, is_drain, x_end, d_end, inner, produce;
    logic [2:0]    mask;
    logic [PIX_W-1:0] px;
    t_pipe_ctl     ctl;

    logic [PIX_W-1:0] b0_rd0, b0_rd1, b1_rd0, b1_rd1;
    logic [PIX_W-1:0] above_p, above_r, two_u, above_now;

    assign rdy3 = !r_v3 || o_pix.ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign i_pix.ready = rdy1;
    assign acc = i_pix.valid && rdy1;
    assign ctl.ld2 = rdy2;
    assign ctl.ld3 = rdy3;

    always_comb begin
        if ({19'd0, cfg.frame_width} > 32'(MAX_WIDTH)) begin
            last = AW'(MAX_WIDTH - 1);
        end else if (cfg.frame_width < 13'd3) begin
            last = AW'(2);
        end else begin
            last = AW'({19'd0, cfg.frame_width} - 32'd1);
        end
    end

    always_comb begin
        fs       = i_pix.data.frame_start;
        is_drain = (i_pix.data.opcode == OP_DRAIN);
        col_e    = fs ? '0 : r_col;
        dr_e     = fs ? '0 : r_drain;
        ph_e     = fs ? PHASE_FIRST : r_phase;
        x        = (col_e > last) ? last : col_e;
        d        = (dr_e > last) ? last : dr_e;
        x_end    = (x == last);
        d_end    = (d == last);
        x_inc    = x + AW'(1);
        inner    = (x != '0) && !x_end;
        produce  = (ph_e != PHASE_FIRST);
        px       = {i_pix.data.chan_c, i_pix.data.chan_b, i_pix.data.chan_a};
        addr_above = is_drain ? d : x;
        if (!is_drain && ph_e == PHASE_INNER && cfg.sharpen_enable && inner) begin
            mask = cfg.luma_only ? 3'b001 : 3'b111;
        end else begin
            mask = 3'b000;
        end
    end

    cks_line_bank #(.DEPTH(MAX_WIDTH), .DW(PIX_W)) u_bank0 (
        .i_clk      (i_clk),
        .i_rd_en    (acc),
        .i_rd_addr0 (!r_sel ? addr_above : x),
        .i_rd_addr1 (x_inc),
        .o_rd_data0 (b0_rd0),
        .o_rd_data1 (b0_rd1),
        .i_wr_en    (acc && !is_drain && r_sel),
        .i_wr_addr  (x),
        .i_wr_data  (px)
    );

    cks_line_bank #(.DEPTH(MAX_WIDTH), .DW(PIX_W)) u_bank1 (
        .i_clk      (i_clk),
        .i_rd_en    (acc),
        .i_rd_addr0 (r_sel ? addr_above : x),
        .i_rd_addr1 (x_inc),
        .o_rd_data0 (b1_rd0),
        .o_rd_data1 (b1_rd1),
        .i_wr_en    (acc && !is_drain && !r_sel),
        .i_wr_addr  (x),
        .i_wr_data  (px)
    );

    // previous transfer's center read is the left neighbor of this one
    assign above_now = r_sel ? b1_rd0 : b0_rd0;
    assign above_p   = r_s1.sel ? b1_rd0 : b0_rd0;
    assign above_r   = r_s1.sel ? b1_rd1 : b0_rd1;
    assign two_u     = r_s1.sel ? b0_rd0 : b1_rd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_drain <= '0;
            r_phase <= PHASE_FIRST;
            r_sel   <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            if (acc) begin
                if (is_drain) begin
                    r_col <= '0;
                    if (produce) begin
                        r_drain <= d_end ? '0 : d + AW'(1);
                        r_phase <= d_end ? PHASE_FIRST : ph_e;
                    end else begin
                        r_drain <= dr_e;
                        r_phase <= ph_e;
                    end
                end else begin
                    r_drain <= '0;
                    if (x_end) begin
                        r_sel   <= !r_sel;
                        r_col   <= '0;
                        r_phase <= (ph_e == PHASE_FIRST) ? PHASE_SECOND : PHASE_INNER;
                    end else begin
                        r_col   <= x_inc;
                        r_phase <= ph_e;
                    end
                end
            end
            if (rdy1) begin
                r_v1 <= acc && produce;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1.mask    <= mask;
            r_s1.row_end <= is_drain ? d_end : x_end;
            r_s1.sel     <= r_sel;
            r_s1.px      <= px;
            r_s1.left    <= above_now;
        end
        if (rdy2) begin
            r_end2 <= r_s1.row_end;
        end
        if (rdy3) begin
            r_end3 <= r_end2;
        end
    end

    logic [15:0] res [3];

    for (genvar k = 0; k < 3; k++) begin : g_chan
        cks_chan_kernel #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_kernel (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_sharpen     (r_s1.mask[k]),
            .i_p           (above_p[16*k +: 16]),
            .i_u           (two_u[16*k +: 16]),
            .i_d           (r_s1.px[16*k +: 16]),
            .i_l           (r_s1.left[16*k +: 16]),
            .i_r           (above_r[16*k +: 16]),
            .i_center_gain (cfg.center_gain),
            .i_h_gain      (cfg.horizontal_gain),
            .i_v_gain      (cfg.vertical_gain),
            .o_res         (res[k])
        );
    end

    assign o_pix.valid        = r_v3;
    assign o_pix.data.out_a   = res[0];
    assign o_pix.data.out_b   = res[1];
    assign o_pix.data.out_c   = res[2];
    assign o_pix.data.row_end = r_end3;

endmodule

// ===== test/tb.sv =====
// testbench of cross_kernel_sharpen_top: random pixel streams checked against a line-buffer predictor
`timescale 1ns / 100ps

module tb;
    import cks_pkg::*;

    localparam int MAX_W       = 4096;
    localparam int FRAC        = 14;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_GOAL = 1250;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    cks_stream_if #(.T(t_pix_in))  pix_in_if ();
    cks_stream_if #(.T(t_pix_out)) pix_out_if ();

    cross_kernel_sharpen_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in_if),
        .o_pix   (pix_out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_cfg        cfg_now;
    t_pix_in     pixel_stream[$];
    t_pix_in     staged[$];
    t_pix_out    expected_pixels[$];
    int          errors      = 0;
    int          cycle_count = 0;
    bit          calm        = 1'b0;
    int          hold_req    = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;

    // line store of the predictor: above_sel picks the bank with the last complete row
    logic [47:0] line_bank [2][MAX_W];
    bit          above_sel;
    int unsigned col_pos;
    int unsigned drain_pos;
    int unsigned row_stage;

    always #5 i_clk = ~i_clk;

    function automatic int unsigned eff_width(logic [12:0] wid);
        if (wid < 3) return 3;
        if (wid > MAX_W) return MAX_W;
        return wid;
    endfunction

    function automatic longint side_term(logic [15:0] gain, logic [15:0] x);
        bit [63:0] t;
        t = (64'(gain) * 64'(x)) >> FRAC;
        return (t > 65535) ? 65535 : longint'(t);
    endfunction

    function automatic logic [15:0] sharpen_channel(logic [15:0] p, logic [15:0] u,
                                                   logic [15:0] d, logic [15:0] l,
                                                   logic [15:0] r);
        longint acc;
        acc = longint'((64'(cfg_now.center_gain) * 64'(p)) >> FRAC);
        acc = acc - side_term(cfg_now.vertical_gain, u) - side_term(cfg_now.vertical_gain, d)
                  - side_term(cfg_now.horizontal_gain, l)
                  - side_term(cfg_now.horizontal_gain, r);
        if (acc < 0) acc = 0;
        if (acc > 65535) acc = 65535;
        return acc[15:0];
    endfunction

    function automatic void push_expected(logic [47:0] px, bit last);
        t_pix_out o;
        o.out_a   = px[15:0];
        o.out_b   = px[31:16];
        o.out_c   = px[47:32];
        o.row_end = last;
        expected_pixels.push_back(o);
    endfunction

    task automatic predict_sharpen(t_pix_in it);
        int unsigned last_col, x, d;
        bit          row_done;
        logic [47:0] px, ctr, res, up, lf, rt;
        last_col = eff_width(cfg_now.frame_width) - 1;
        if (it.frame_start) begin
            col_pos   = 0;
            row_stage = 0;
            drain_pos = 0;
        end
        if (it.opcode == OP_DRAIN) begin
            col_pos = 0;
            if (row_stage != 0) begin
                d = (drain_pos > last_col) ? last_col : drain_pos;
                row_done = (d >= last_col);
                push_expected(line_bank[above_sel][d], row_done);
                if (row_done) begin
                    drain_pos = 0;
                    row_stage = 0;
                end else begin
                    drain_pos = d + 1;
                end
            end
        end else begin
            px = {it.chan_c, it.chan_b, it.chan_a};
            drain_pos = 0;
            x = (col_pos > last_col) ? last_col : col_pos;
            row_done = (x >= last_col);
            if (row_stage == 1) begin
                push_expected(line_bank[above_sel][x], row_done);
            end else if (row_stage >= 2) begin
                ctr = line_bank[above_sel][x];
                res = ctr;
                if (cfg_now.sharpen_enable && x != 0 && x != last_col) begin
                    up = line_bank[!above_sel][x];
                    lf = line_bank[above_sel][x - 1];
                    rt = line_bank[above_sel][x + 1];
                    for (int k = 0; k < (cfg_now.luma_only ? 1 : 3); k++)
                        res[16*k +: 16] = sharpen_channel(ctr[16*k +: 16], up[16*k +: 16],
                                                          px[16*k +: 16], lf[16*k +: 16],
                                                          rt[16*k +: 16]);
                end
                push_expected(res, row_done);
            end
            line_bank[!above_sel][x] = px;
            if (row_done) begin
                above_sel = !above_sel;
                col_pos   = 0;
                if (row_stage < 2) row_stage++;
            end else begin
                col_pos = x + 1;
            end
        end
    endtask

    // sender: transfer accepted when valid and ready are both high at the edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_in_if.valid <= 1'b0;
            pix_in_if.data  <= '0;
        end else begin
            if (pix_in_if.valid && pix_in_if.ready) predict_sharpen(pix_in_if.data);
            if (!pix_in_if.valid || pix_in_if.ready) begin
                if (pixel_stream.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
                    pix_in_if.valid <= 1'b1;
                    pix_in_if.data  <= pixel_stream.pop_front();
                end else begin
                    pix_in_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver with random stalls and one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            pix_out_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            pix_out_if.ready <= 1'b0;
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else begin
            pix_out_if.ready <= calm || $urandom_range(99) >= 8;
        end
    end

    function automatic void report_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pix_out want, got;
        if (i_rst_n && pix_out_if.valid && pix_out_if.ready) begin
            got = pix_out_if.data;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                report_field("out_a", want.out_a, got.out_a);
                report_field("out_b", want.out_b, got.out_b);
                report_field("out_c", want.out_c, got.out_c);
                report_field("row_end", 16'(want.row_end), 16'(got.row_end));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cross_kernel_sharpen_top test failed");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:     cfg_now.frame_width     = val[12:0];
            REG_SHARPEN_ENABLE:  cfg_now.sharpen_enable  = val[0];
            REG_LUMA_ONLY:       cfg_now.luma_only       = val[0];
            REG_CENTER_GAIN:     cfg_now.center_gain     = val[17:0];
            REG_HORIZONTAL_GAIN: cfg_now.horizontal_gain = val[15:0];
            REG_VERTICAL_GAIN:   cfg_now.vertical_gain   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [12:0] wid, logic en, logic luma, logic [17:0] c_gain,
                              logic [15:0] h_gain, logic [15:0] v_gain);
        apb_write(REG_FRAME_WIDTH, 32'(wid));
        apb_write(REG_SHARPEN_ENABLE, 32'(en));
        apb_write(REG_LUMA_ONLY, 32'(luma));
        apb_write(REG_CENTER_GAIN, 32'(c_gain));
        apb_write(REG_HORIZONTAL_GAIN, 32'(h_gain));
        apb_write(REG_VERTICAL_GAIN, 32'(v_gain));
    endtask

    function automatic int unsigned to_gain(real x, int unsigned top);
        real n;
        n = x * (1 << FRAC) + 0.5;
        if (n >= top) return top;
        return $rtoi(n);
    endfunction

    task automatic pick_gains(output logic [17:0] c_gain, output logic [15:0] h_gain,
                              output logic [15:0] v_gain, output logic en);
        real s, bias, g, hg, vg;
        case ($urandom_range(0, 3))
            0: begin
                // gains derived from a random strength and bias
                s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) / 1000.0
                                                : $urandom_range(0, 3000) / 1000.0;
                bias   = ($itor($urandom_range(0, 1000)) - 500.0) / 1000.0;
                g      = 0.55 * $pow(s, 1.5);
                hg     = g * (1.0 - bias);
                vg     = g * (1.0 + bias);
                c_gain = 18'(to_gain(1.0 + 2.0 * hg + 2.0 * vg, 32'h3ffff));
                h_gain = 16'(to_gain(hg, 32'hffff));
                v_gain = 16'(to_gain(vg, 32'hffff));
                en     = s > 0.005;
            end
            1: begin
                c_gain = $urandom_range(1) ? 18'h3ffff : 18'h0;
                h_gain = $urandom_range(1) ? 16'hffff : 16'h0;
                v_gain = $urandom_range(1) ? 16'hffff : 16'h0;
                en     = $urandom_range(9) != 0;
            end
            2: begin
                c_gain = 18'($urandom_range(0, 32'h3ffff));
                h_gain = 16'($urandom_range(0, 32'hffff));
                v_gain = 16'($urandom_range(0, 32'hffff));
                en     = $urandom_range(9) != 0;
            end
            default: begin
                h_gain = 16'($urandom_range(0, 4000));
                v_gain = 16'($urandom_range(0, 4000));
                c_gain = 18'd16384 + {h_gain, 1'b0} + {v_gain, 1'b0};
                en     = $urandom_range(9) != 0;
            end
        endcase
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic t_pix_in make_item(logic op, logic fs, logic [15:0] a, logic [15:0] b,
                                          logic [15:0] c);
        t_pix_in it;
        it.opcode      = op;
        it.frame_start = fs;
        it.chan_a      = a;
        it.chan_b      = b;
        it.chan_c      = c;
        return it;
    endfunction

    function automatic void stage_drains(int unsigned n);
        for (int i = 0; i < n; i++)
            staged.push_back(make_item(OP_DRAIN, i == 0 && $urandom_range(19) == 0,
                                       pick_sample(), pick_sample(), pick_sample()));
    endfunction

    // well-formed frame with a little noise: stray drains and restarts mid-row
    function automatic void stage_frame(int unsigned cols, int unsigned rows);
        for (int r = 0; r < rows; r++) begin
            for (int x = 0; x < cols; x++) begin
                if ($urandom_range(99) < 3) stage_drains($urandom_range(1, 3));
                staged.push_back(make_item(OP_PIXEL,
                                           (r == 0 && x == 0) || $urandom_range(199) == 0,
                                           pick_sample(), pick_sample(), pick_sample()));
            end
        end
        if ($urandom_range(9) != 0)
            stage_drains(cols + (($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0));
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_stream.size() != 0 || pix_in_if.valid || expected_pixels.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_staged(bit split, bit quiet, bit hold);
        int unsigned half;
        @(negedge i_clk);
        calm = quiet;
        half = split ? staged.size() / 2 : staged.size();
        for (int i = 0; i < half; i++) pixel_stream.push_back(staged.pop_front());
        if (hold) hold_req++;
        if (split) begin
            wait_idle();
            @(negedge i_clk);
        end
        while (staged.size() != 0) pixel_stream.push_back(staged.pop_front());
        wait_idle();
        @(negedge i_clk);
        calm = 1'b0;
    endtask

    initial begin
        int unsigned random_items, phase, cols;
        logic [12:0] wid_cfg;
        logic [17:0] c_gain;
        logic [15:0] h_gain, v_gain;
        logic        en;

        cfg_now.frame_width     = RST_FRAME_WIDTH;
        cfg_now.sharpen_enable  = 1'b0;
        cfg_now.luma_only       = 1'b0;
        cfg_now.center_gain     = RST_CENTER_GAIN;
        cfg_now.horizontal_gain = '0;
        cfg_now.vertical_gain   = '0;
        above_sel = 1'b0;
        col_pos   = 0;
        drain_pos = 0;
        row_stage = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // narrowest frame with saturating gains
        set_config(13'd3, 1'b1, 1'b0, 18'h3ffff, 16'hffff, 16'hffff);
        staged.push_back(make_item(OP_DRAIN, 1'b1, 16'h1111, 16'h2222, 16'h3333));
        staged.push_back(make_item(OP_PIXEL, 1'b0, 16'h0000, 16'h0000, 16'h0000));
        staged.push_back(make_item(OP_PIXEL, 1'b0, 16'hffff, 16'hffff, 16'hffff));
        staged.push_back(make_item(OP_PIXEL, 1'b0, 16'haaaa, 16'h5555, 16'h8000));
        staged.push_back(make_item(OP_PIXEL, 1'b0, 16'h1234, 16'h4000, 16'h00ff));
        staged.push_back(make_item(OP_PIXEL, 1'b0, 16'hffff, 16'h0000, 16'h8000));
        staged.push_back(make_item(OP_PIXEL, 1'b0, 16'h5555, 16'haaaa, 16'h0001));
        staged.push_back(make_item(OP_PIXEL, 1'b0, 16'hffff, 16'hffff, 16'hffff));
        staged.push_back(make_item(OP_PIXEL, 1'b0, 16'hffff, 16'hffff, 16'hffff));
        staged.push_back(make_item(OP_PIXEL, 1'b0, 16'h0000, 16'h0000, 16'h0000));
        staged.push_back(make_item(OP_PIXEL, 1'b0, 16'h0f0f, 16'hf0f0, 16'h7fff));
        staged.push_back(make_item(OP_DRAIN, 1'b0, 16'h0000, 16'h0000, 16'h0000));
        staged.push_back(make_item(OP_PIXEL, 1'b0, 16'h8001, 16'h0180, 16'hc3c3));
        staged.push_back(make_item(OP_PIXEL, 1'b0, 16'h0001, 16'hfffe, 16'h7777));
        staged.push_back(make_item(OP_PIXEL, 1'b0, 16'hfffe, 16'h0001, 16'h3c3c));
        stage_drains(3);
        staged.push_back(make_item(OP_DRAIN, 1'b0, 16'hffff, 16'hffff, 16'hffff));
        send_staged(1'b0, 1'b0, 1'b0);

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_GOAL) begin
            case ($urandom_range(0, 9))
                0:       wid_cfg = 13'($urandom_range(0, 2));
                1, 2:    wid_cfg = 13'($urandom_range(11, 40));
                default: wid_cfg = 13'($urandom_range(3, 10));
            endcase
            if (phase == 2) wid_cfg = 13'd16;
            pick_gains(c_gain, h_gain, v_gain, en);
            set_config(wid_cfg, en, $urandom_range(0, 2) == 0, c_gain, h_gain, v_gain);
            cols = eff_width(wid_cfg);
            stage_frame(cols, (phase == 2) ? 4 : $urandom_range(2, 5));
            random_items += staged.size();
            send_staged(phase == 3, phase == 1, phase == 2);
            phase++;
        end

        if (errors == 0)
            $display("cross_kernel_sharpen_top test passed");
        else
            $display("cross_kernel_sharpen_top test failed");
        $finish;
    end

endmodule
